@@ hw/rtl/fcgi_pkg.sv @@
// shared types, codes and constants of the fastcgi record deframer
`timescale 1ns / 1ps
package fcgi_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_ID     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_REQUEST = 1'b1;

  localparam logic [15:0] MATCH_ID_RST = 16'd1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;

  localparam logic [7:0] REC_END_REQUEST = 8'd3;
  localparam logic [7:0] REC_STDOUT      = 8'd6;
  localparam logic [7:0] REC_STDERR      = 8'd7;

  // byte positions inside a record header
  localparam logic [2:0] HB_TYPE   = 3'd1;
  localparam logic [2:0] HB_ID_HI  = 3'd2;
  localparam logic [2:0] HB_ID_LO  = 3'd3;
  localparam logic [2:0] HB_LEN_HI = 3'd4;
  localparam logic [2:0] HB_LEN_LO = 3'd5;
  localparam logic [2:0] HB_PAD    = 3'd6;
  localparam logic [2:0] HB_LAST   = 3'd7;

  localparam logic [1:0] KIND_DROP   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_BODY   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_HEADERS_END = 3'd1;
  localparam logic [2:0] EV_DONE_NOBODY = 3'd2;
  localparam logic [2:0] EV_BODY_END    = 3'd3;
  localparam logic [2:0] EV_PREMATURE   = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADERS = 2'd0,
    PH_NO_BODY = 2'd1,
    PH_BODY    = 2'd2
  } fcgi_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_newline;
    logic       is_text;
  } fcgi_item_t;

endpackage

@@ hw/rtl/fcgi_ifs.sv @@
// request channel interfaces of the fastcgi record deframer
`timescale 1ns / 1ps
interface fcgi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fcgi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] event_res;

  modport source (output valid, output out_byte, output out_kind, output event_res,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input event_res,
                output ready);
endinterface

@@ hw/rtl/fastcgi_record_deframer.sv @@
// top level of the fastcgi record deframer
//
// takes a fastcgi response stream on in_ch, one byte per request, and gives
// exactly one result per byte on out_ch: the byte with its kind (dropped or
// framing, header text, body, error stream) and an event code (headers
// ended, done without body, body end, premature end of headers).
// records of another request id or of an unhandled type are skipped.
// cfg_we/cfg_index/cfg_data write the matching record id (index 0) and
// head_request (index 1); write them only while no byte is in flight.
// an accepted byte passes the byte queue and then the output register to out_ch.
// throughput: one byte per cycle while out_ch takes results; the back end updates
// all framing state once per byte, behind a QUEUE_DEPTH entry byte queue.
// a stalled receiver holds the output register; the queue keeps taking
// bytes until full, then in_ch.ready drops.
// reset (rst_n low, synchronous) empties the queue and output register,
// sets the matching id to 1, head_request to 0 and restarts at a record header.
`timescale 1ns / 1ps
module fastcgi_record_deframer
  import fcgi_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fcgi_in_if.sink                in_ch,
  fcgi_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       push_valid, push_ready;
  fcgi_item_t push_item;
  logic       q_valid, q_pop;
  fcgi_item_t q_item;

  fcgi_front u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  fcgi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  fcgi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/fcgi_front.sv @@
// front end: accepts input bytes and classifies them for the queue
`timescale 1ns / 1ps
module fcgi_front
  import fcgi_pkg::*;
(
  fcgi_in_if.sink    in_ch,
  input  logic       push_ready,
  output logic       push_valid,
  output fcgi_item_t push_item
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_item.data_byte  = in_ch.data_byte;
    push_item.is_newline = (in_ch.data_byte == NEWLINE_BYTE);
    push_item.is_text    = (in_ch.data_byte > SPACE_BYTE);
  end

endmodule

@@ hw/rtl/fcgi_queue.sv @@
// short queue of classified bytes between front and back end
`timescale 1ns / 1ps
module fcgi_queue
  import fcgi_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  fcgi_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output fcgi_item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fcgi_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/fcgi_back.sv @@
// back end: record framing state, configuration registers and output register
`timescale 1ns / 1ps
module fcgi_back
  import fcgi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_valid,
  input  fcgi_item_t             q_item,
  output logic                   q_pop,
  fcgi_out_if.source             out_ch
);

  logic [15:0]  match_id_r;
  logic         head_request_r;

  logic [7:0]   hdr_store_r [8];
  logic [2:0]   hdr_count_r, hdr_count_nxt;
  logic [15:0]  content_left_r, content_left_nxt;
  logic [16:0]  skip_left_r, skip_left_nxt;
  fcgi_phase_t  phase_r, phase_nxt;
  logic         on_err_r, on_err_nxt;
  logic         line_text_r, line_text_nxt;
  logic         finished_r, finished_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r;
  logic [1:0]   out_kind_r;
  logic [2:0]   event_r;

  logic         step;
  logic         hdr_we;
  logic [1:0]   kind;
  logic [2:0]   ev;
  logic         to_skip;
  logic [7:0]   rec_type;
  logic [15:0]  rec_id;
  logic [15:0]  rec_len;
  logic [7:0]   rec_pad;
  logic [15:0]  content_dec;

  assign step  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = step;

  assign rec_type    = hdr_store_r[HB_TYPE];
  assign rec_id      = {hdr_store_r[HB_ID_HI], hdr_store_r[HB_ID_LO]};
  assign rec_len     = {hdr_store_r[HB_LEN_HI], hdr_store_r[HB_LEN_LO]};
  assign rec_pad     = hdr_store_r[HB_PAD];
  assign content_dec = content_left_r - 16'd1;

  always_comb begin
    hdr_count_nxt    = hdr_count_r;
    content_left_nxt = content_left_r;
    skip_left_nxt    = skip_left_r;
    phase_nxt        = phase_r;
    on_err_nxt       = on_err_r;
    line_text_nxt    = line_text_r;
    finished_nxt     = finished_r;
    hdr_we           = 1'b0;
    kind             = KIND_DROP;
    ev               = EV_NONE;
    to_skip          = 1'b0;
    if (finished_r) begin
      // everything after the end of the response is dropped
    end else if (content_left_r != 16'd0) begin
      content_left_nxt = content_dec;
      if (on_err_r) begin
        kind = KIND_ERROR;
      end else if (phase_r == PH_HEADERS) begin
        kind = KIND_HEADER;
        if (q_item.is_newline) begin
          if (!line_text_r) begin
            ev         = EV_HEADERS_END;
            on_err_nxt = 1'b0;
            if (head_request_r) begin
              phase_nxt        = PH_NO_BODY;
              skip_left_nxt    = skip_left_r + {1'b0, content_dec};
              content_left_nxt = 16'd0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          line_text_nxt = 1'b0;
        end else if (q_item.is_text) begin
          line_text_nxt = 1'b1;
        end
      end else if (phase_r == PH_BODY) begin
        kind = KIND_BODY;
      end
    end else if (skip_left_r != 17'd0) begin
      skip_left_nxt = skip_left_r - 17'd1;
    end else begin
      hdr_we        = 1'b1;
      hdr_count_nxt = hdr_count_r + 3'd1;
      if (hdr_count_r == HB_LAST) begin
        content_left_nxt = rec_len;
        skip_left_nxt    = {9'd0, rec_pad};
        if (rec_id != match_id_r) begin
          to_skip = 1'b1;
        end else begin
          case (rec_type)
            REC_STDOUT: begin
              on_err_nxt = 1'b0;
              if (phase_r == PH_NO_BODY) begin
                to_skip = 1'b1;
              end
            end
            REC_STDERR: begin
              on_err_nxt = 1'b1;
            end
            REC_END_REQUEST: begin
              finished_nxt = 1'b1;
              case (phase_r)
                PH_HEADERS: begin
                  ev = EV_PREMATURE;
                end
                PH_NO_BODY: begin
                  ev = EV_DONE_NOBODY;
                end
                default: begin
                  ev = EV_BODY_END;
                end
              endcase
            end
            default: begin
              to_skip = 1'b1;
            end
          endcase
        end
        if (to_skip) begin
          skip_left_nxt    = {9'd0, rec_pad} + {1'b0, rec_len};
          content_left_nxt = 16'd0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_id_r     <= MATCH_ID_RST;
      head_request_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_ID: begin
          match_id_r <= cfg_data[15:0];
        end
        CFG_HEAD_REQUEST: begin
          head_request_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_count_r    <= '0;
      content_left_r <= '0;
      skip_left_r    <= '0;
      phase_r        <= PH_HEADERS;
      on_err_r       <= 1'b0;
      line_text_r    <= 1'b0;
      finished_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        hdr_count_r    <= hdr_count_nxt;
        content_left_r <= content_left_nxt;
        skip_left_r    <= skip_left_nxt;
        phase_r        <= phase_nxt;
        on_err_r       <= on_err_nxt;
        line_text_r    <= line_text_nxt;
        finished_r     <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= (kind != KIND_DROP) ? q_item.data_byte : 8'd0;
      out_kind_r <= kind;
      event_r    <= ev;
      if (hdr_we) begin
        hdr_store_r[hdr_count_r] <= q_item.data_byte;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.out_kind  = out_kind_r;
  assign out_ch.event_res = event_r;

endmodule

@@ hw/rtl/fcgi_checker.sv @@
// port checker of the fastcgi record deframer and its bind
`timescale 1ns / 1ps
module fcgi_checker
  import fcgi_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic [2:0] event_res
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
                               && $stable(event_res))
    else $error("stalled result changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DROP |-> out_byte == 8'd0)
    else $error("dropped byte not cleared");

  a_event_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_HEADERS_END |-> out_kind == KIND_HEADER)
    else $error("headers end not on header text");

  a_end_framing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_DONE_NOBODY || event_res == EV_BODY_END
                  || event_res == EV_PREMATURE) |-> out_kind == KIND_DROP)
    else $error("end event on a passed byte");

endmodule

bind fastcgi_record_deframer fcgi_checker u_fcgi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_kind  (out_ch.out_kind),
  .event_res (out_ch.event_res)
);
